// ===== src/egcd_pkg.sv =====
// Shared types and constants for the extended gcd block.
// No dependencies; imported by egcd_step and extended_gcd_bezout.
package egcd_pkg;

	localparam int DEF_OPERAND_BITS = 31;
	localparam int DIV_W            = 31;  // width of the gcd result field
	localparam int COEF_W           = 32;  // width of each Bezout coefficient field

	// One value per coefficient sequence (x and y)
	typedef struct packed {
		logic [COEF_W-1:0] x;
		logic [COEF_W-1:0] y;
	} coef_pair_t;

endpackage

// ===== src/egcd_step.sv =====
// One radix-2 restoring division step, plus the Horner update of q*x and q*y.
// Depends on egcd_pkg.
module egcd_step #(
	parameter int OPERAND_BITS = egcd_pkg::DEF_OPERAND_BITS
) (
	input  logic [OPERAND_BITS-1:0] rem,
	input  logic                    next_bit,
	input  logic [OPERAND_BITS-1:0] divisor,
	input  egcd_pkg::coef_pair_t    mult,
	input  egcd_pkg::coef_pair_t    prod,
	output logic [OPERAND_BITS-1:0] rem_next,
	output egcd_pkg::coef_pair_t    prod_next
);
	import egcd_pkg::*;

	logic [OPERAND_BITS:0] trial;
	logic [OPERAND_BITS:0] diff;
	logic                  take;

	assign trial = {rem, next_bit};
	assign diff  = trial - {1'b0, divisor};
	// no borrow means the quotient bit is one
	assign take  = ~diff[OPERAND_BITS];

	assign rem_next    = take ? diff[OPERAND_BITS-1:0] : trial[OPERAND_BITS-1:0];
	// quotient is built MSB first, so q*x accumulates as prod = 2*prod + bit*x
	assign prod_next.x = {prod.x[COEF_W-2:0], 1'b0} + (take ? mult.x : '0);
	assign prod_next.y = {prod.y[COEF_W-2:0], 1'b0} + (take ? mult.y : '0);

endmodule

// ===== src/extended_gcd_bezout.sv =====
// Top level of the extended gcd block: stream ports, sequencer, output register.
// Depends on egcd_pkg and egcd_step.

// Returns g = gcd(a, b) and coefficients x, y with a*x + b*y = g (x, y two's
// complement, taken modulo 2^32). One request is worked at a time: the input is
// ready only while the sequencer is idle. Each Euclid step runs a bit-serial
// division through the single shared step unit, one quotient bit per cycle,
// then updates the remainders and coefficients. A finished result sits in the
// output register, and the next request is taken while it waits.
module extended_gcd_bezout #(
	parameter int OPERAND_BITS = egcd_pkg::DEF_OPERAND_BITS,
	localparam int IN_W  = ((2 * OPERAND_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((egcd_pkg::DIV_W + 2 * egcd_pkg::COEF_W + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,   // first_value, second_value, zero pad
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata    // divisor, coef_first, coef_second, zero pad
);
	import egcd_pkg::*;

	localparam int CNT_W = $clog2(OPERAND_BITS);
	localparam int PAD_W = OUT_W - DIV_W - 2 * COEF_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CHK  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_UPD  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]              state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [OPERAND_BITS-1:0] rp_q, rc_q, rem_q, dvd_q;
	coef_pair_t              prev_q, cur_q, prod_q;
	logic                    out_valid_q;
	logic [DIV_W-1:0]        out_div_q;
	coef_pair_t              out_coef_q;

	logic [OPERAND_BITS-1:0] rem_next;
	coef_pair_t              prod_next;
	logic                    in_acc, out_load;

	egcd_step #(.OPERAND_BITS(OPERAND_BITS)) u_step (
		.rem      (rem_q),
		.next_bit (dvd_q[OPERAND_BITS-1]),
		.divisor  (rc_q),
		.mult     (cur_q),
		.prod     (prod_q),
		.rem_next (rem_next),
		.prod_next(prod_next)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid & s_axis_tready;
	assign out_load      = (state_q == ST_DONE) & (~out_valid_q | m_axis_tready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (in_acc) state_q <= ST_CHK;
				ST_CHK:  state_q <= (rc_q == '0) ? ST_DONE : ST_DIV;
				ST_DIV:  if (cnt_q == '0) state_q <= ST_UPD;
				ST_UPD:  state_q <= ST_CHK;
				ST_DONE: if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					rp_q   <= s_axis_tdata[OPERAND_BITS-1:0];
					rc_q   <= s_axis_tdata[2*OPERAND_BITS-1:OPERAND_BITS];
					prev_q <= '{x: COEF_W'(1), y: '0};
					cur_q  <= '{x: '0, y: COEF_W'(1)};
				end
			end
			ST_CHK: begin
				rem_q  <= '0;
				prod_q <= '0;
				dvd_q  <= rp_q;
				cnt_q  <= CNT_W'(OPERAND_BITS - 1);
			end
			ST_DIV: begin
				rem_q  <= rem_next;
				prod_q <= prod_next;
				dvd_q  <= {dvd_q[OPERAND_BITS-2:0], 1'b0};
				cnt_q  <= cnt_q - 1'b1;
			end
			ST_UPD: begin
				rp_q     <= rc_q;
				rc_q     <= rem_q;
				prev_q   <= cur_q;
				cur_q.x  <= prev_q.x - prod_q.x;
				cur_q.y  <= prev_q.y - prod_q.y;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_div_q  <= DIV_W'(rp_q);
			out_coef_q <= prev_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, out_coef_q.y, out_coef_q.x, out_div_q};

	// remainder stays below the divisor throughout the division
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < rc_q))
		else $error("division remainder not below divisor");

	// each Euclid step strictly shrinks the remainder
	a_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |=> (rc_q < rp_q))
		else $error("remainder sequence did not decrease");

	// a request always enters the zero test next
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_CHK))
		else $error("accepted request did not start");

	// output register is only reloaded when empty or being drained
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |-> !out_load)
		else $error("pending result overwritten");

endmodule
